[hdl/lcc_pkg.sv]
// ----------------------------------------------------------------------------
// Luhn card number check: shared package
// Widths, range classes and prefix bounds, and the small digit functions
// used by the checksum stages and the top level; the cells use the widths.
// ----------------------------------------------------------------------------
package lcc_pkg;

   // Width of the binary card number and of the decimal window that is checked.
   localparam int CARD_WIDTH  = 54;
   localparam int DIGIT_COUNT = 16;
   localparam int BCD_WIDTH   = DIGIT_COUNT * 4;

   // One conversion cell per input bit.
   localparam int CELL_COUNT  = CARD_WIDTH;

   // Checksum adder tree: groups of four mapped digits, then the total.
   localparam int GROUP_SIZE  = 4;
   localparam int GROUP_COUNT = (DIGIT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int GROUP_WIDTH = $clog2(9 * GROUP_SIZE + 1);
   localparam int SUM_MAX     = 9 * DIGIT_COUNT;
   localparam int SUM_WIDTH   = $clog2(SUM_MAX + 1);
   localparam int TENS_COUNT  = SUM_MAX / 10;

   // Prefix and length ranges.
   localparam logic [CARD_WIDTH-1:0] P34_LOW  = 54'd340000000000000;
   localparam logic [CARD_WIDTH-1:0] P34_HIGH = 54'd349999999999999;
   localparam logic [CARD_WIDTH-1:0] P37_LOW  = 54'd370000000000000;
   localparam logic [CARD_WIDTH-1:0] P37_HIGH = 54'd379999999999999;
   localparam logic [CARD_WIDTH-1:0] P5X_LOW  = 54'd5100000000000000;
   localparam logic [CARD_WIDTH-1:0] P5X_HIGH = 54'd5599999999999999;
   localparam logic [CARD_WIDTH-1:0] P4S_LOW  = 54'd4000000000000;
   localparam logic [CARD_WIDTH-1:0] P4S_HIGH = 54'd4999999999999;
   localparam logic [CARD_WIDTH-1:0] P4L_LOW  = 54'd4000000000000000;
   localparam logic [CARD_WIDTH-1:0] P4L_HIGH = 54'd4999999999999999;

   typedef enum logic [2:0] {
      CLASS_NONE     = 3'd0,
      CLASS_15_34    = 3'd1,
      CLASS_15_37    = 3'd2,
      CLASS_16_51_55 = 3'd3,
      CLASS_13_4     = 3'd4,
      CLASS_16_4     = 3'd5
   } range_class_type;

   // Payload that travels down the conversion chain.
   typedef struct packed {
      logic [CARD_WIDTH-1:0] bin;
      logic [BCD_WIDTH-1:0]  bcd;
      range_class_type       cls;
   } lcc_item_type;

   // Finished result.
   typedef struct packed {
      range_class_type cls;
      logic            luhn_ok;
      logic            accepted;
   } lcc_result_type;

   // Decide the range class; the last matching range wins.
   function automatic range_class_type classify(input logic [CARD_WIDTH-1:0] v);
      range_class_type c;
      c = CLASS_NONE;
      if (v >= P4L_LOW && v <= P4L_HIGH) c = CLASS_16_4;
      if (v >= P4S_LOW && v <= P4S_HIGH) c = CLASS_13_4;
      if (v >= P5X_LOW && v <= P5X_HIGH) c = CLASS_16_51_55;
      if (v >= P37_LOW && v <= P37_HIGH) c = CLASS_15_37;
      if (v >= P34_LOW && v <= P34_HIGH) c = CLASS_15_34;
      return c;
   endfunction

   // Luhn weight of one digit: doubled digits have their two digits added.
   function automatic logic [3:0] luhn_map(input logic [3:0] d, input logic doubled);
      logic [4:0] twice;
      twice = {d, 1'b0};
      if (!doubled) return d;
      if (twice > 5'd9) return 4'(twice - 5'd9);
      return twice[3:0];
   endfunction

endpackage

[hdl/lcc_cell.sv]
// ----------------------------------------------------------------------------
// Luhn card number check: conversion cell
// One shift-and-add-three step of the binary to decimal conversion. Each
// cell corrects every decimal digit, then shifts one binary bit in.
// ----------------------------------------------------------------------------
module lcc_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 valid_i,
   input  lcc_pkg::lcc_item_type item_i,
   output logic                 valid_o,
   output lcc_pkg::lcc_item_type item_o
);
   import lcc_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   lcc_item_type         item_ff;
   lcc_item_type         item_in;
   logic [BCD_WIDTH-1:0] bcd_adj;

   // Add three to every digit of five or more, then shift the next bit in.
   always_comb begin
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (item_i.bcd[d*4 +: 4] >= 4'd5) begin
            bcd_adj[d*4 +: 4] = item_i.bcd[d*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[d*4 +: 4] = item_i.bcd[d*4 +: 4];
         end
      end
      item_in.bcd = {bcd_adj[BCD_WIDTH-2:0], item_i.bin[CARD_WIDTH-1]};
      item_in.bin = {item_i.bin[CARD_WIDTH-2:0], 1'b0};
      item_in.cls = item_i.cls;
      valid_in    = valid_i;
   end

   // The occupancy flag is reset; the payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= item_in;
      end
   end

   assign valid_o = valid_ff;
   assign item_o  = item_ff;

endmodule

[hdl/lcc_sum.sv]
// ----------------------------------------------------------------------------
// Luhn card number check: checksum stages
// Two registered stages: weighted digits summed in groups of four, then the
// group total tested for a multiple of ten and combined with the range class.
// ----------------------------------------------------------------------------
module lcc_sum (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   valid_i,
   input  lcc_pkg::lcc_item_type   item_i,
   output logic                   valid_o,
   output lcc_pkg::lcc_result_type result_o
);
   import lcc_pkg::*;

   logic [GROUP_WIDTH-1:0] group_ff [GROUP_COUNT];
   logic [GROUP_WIDTH-1:0] group_in [GROUP_COUNT];
   range_class_type        cls_ff;
   logic                   stage_a_valid_ff;
   logic                   result_valid_ff;
   lcc_result_type         result_ff;
   lcc_result_type         result_in;
   logic [SUM_WIDTH-1:0]   total;
   logic                   multiple_of_ten;

   // Stage A: weight each digit (odd positions from the right are doubled)
   // and add them in groups of four.
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < DIGIT_COUNT) begin
               group_in[g] = group_in[g] + GROUP_WIDTH'(luhn_map(
                  item_i.bcd[(g*GROUP_SIZE+j)*4 +: 4], ((g * GROUP_SIZE + j) % 2) == 1));
            end
         end
      end
   end

   // Stage B: total of the groups and the multiple-of-ten test.
   always_comb begin
      total = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         total = total + SUM_WIDTH'(group_ff[g]);
      end
      multiple_of_ten = 1'b0;
      for (int k = 0; k <= TENS_COUNT; k++) begin
         if (total == SUM_WIDTH'(k * 10)) multiple_of_ten = 1'b1;
      end
      result_in.cls      = cls_ff;
      result_in.luhn_ok  = multiple_of_ten;
      result_in.accepted = multiple_of_ten && (cls_ff != CLASS_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_a_valid_ff <= 1'b0;
         result_valid_ff  <= 1'b0;
      end else if (advance) begin
         stage_a_valid_ff <= valid_i;
         result_valid_ff  <= stage_a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         group_ff  <= group_in;
         cls_ff    <= item_i.cls;
         result_ff <= result_in;
      end
   end

   assign valid_o  = result_valid_ff;
   assign result_o = result_ff;

endmodule

[hdl/luhn_card_number_check.sv]
// ----------------------------------------------------------------------------
// Luhn card number check: top level
// Classifies a binary card number by prefix and length and runs the Luhn
// mod-10 check on its lowest sixteen decimal digits.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, req_card_number) takes one card
// number per transfer. The response channel (rsp_valid, rsp_stall and the
// three result ports) returns one result per request, in order.
// A number passes 57 registers from the accepting edge to rsp_valid: 54
// binary-to-decimal cells (one per input bit), two checksum stages and the
// output register, and the first cell loads at that edge.
// Throughput is one number per cycle while the skid register is empty, set by
// the cell chain, which advances whenever the skid register is free.
// When the receiver stalls, the result waits in the output register and the
// next one drops into a one-entry skid register; only while that skid entry
// is full does req_stall rise and the whole chain hold.
// Synchronous reset empties the chain, the output and the skid register;
// req_stall is low after reset.
// ----------------------------------------------------------------------------
module luhn_card_number_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lcc_pkg::CARD_WIDTH-1:0]  req_card_number,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_range_class,
   output logic                            rsp_luhn_ok,
   output logic                            rsp_accepted
);
   import lcc_pkg::*;

   logic           advance;
   logic           take;
   logic           chain_valid [CELL_COUNT+1];
   lcc_item_type   chain_item  [CELL_COUNT+1];
   logic           sum_valid;
   lcc_result_type sum_result;

   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   lcc_result_type out_ff;
   lcc_result_type out_in;
   logic           skid_valid_ff;
   logic           skid_valid_in;
   lcc_result_type skid_ff;
   lcc_result_type skid_in;

   // The chain moves whenever the skid register is free.
   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign take      = rsp_valid_ff && !rsp_stall;

   // Head of the chain: classify the number and start with an empty BCD word.
   assign chain_valid[0]    = req_valid && !req_stall;
   assign chain_item[0].bin = req_card_number;
   assign chain_item[0].bcd = '0;
   assign chain_item[0].cls = classify(req_card_number);

   // Binary to decimal conversion, one input bit per cell.
   for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
      lcc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (chain_valid[c]),
         .item_i  (chain_item[c]),
         .valid_o (chain_valid[c+1]),
         .item_o  (chain_item[c+1])
      );
   end

   // Luhn checksum and acceptance.
   lcc_sum u_sum (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .valid_i  (chain_valid[CELL_COUNT]),
      .item_i   (chain_item[CELL_COUNT]),
      .valid_o  (sum_valid),
      .result_o (sum_result)
   );

   // Output register with skid entry.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (sum_valid) begin
         if (!rsp_valid_ff || take) begin
            out_in       = sum_result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = sum_result;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_class = out_ff.cls;
   assign rsp_luhn_ok     = out_ff.luhn_ok;
   assign rsp_accepted    = out_ff.accepted;

   // The skid entry only fills behind a result that is still waiting.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry full while output register is empty");

   // A held chain must not lose or create its last item.
   a_chain_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(sum_valid))
      else $error("checksum stage changed while the chain was held");

   // Acceptance needs both a listed range and a passing checksum.
   a_accept_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!out_ff.accepted ||
                        (out_ff.luhn_ok && out_ff.cls != CLASS_NONE)))
      else $error("accepted without range or checksum");

   // A result leaving while the skid entry is full is replaced by that entry.
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && take) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to the output register");

endmodule
